[hw/rtl/hks_pkg.sv]
// shared types and constants for the hid keystroke token sequencer
package hks_pkg;

	localparam logic [15:0] DEBOUNCE_RELOAD_RST = 16'd250;
	localparam logic [7:0]  FRAME_DIVIDE_RST    = 8'd2;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_START  = 4'd1,
		PH_FETCH  = 4'd2,
		PH_KDOWN  = 4'd3,
		PH_KUP    = 4'd4,
		PH_MDOWN  = 4'd5,
		PH_MKDOWN = 4'd6,
		PH_MKUP   = 4'd7,
		PH_MUP    = 4'd8,
		PH_PAUSE  = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_OPEN  = 3'd1,
		ACT_CLOSE = 3'd2,
		ACT_KDOWN = 3'd3,
		ACT_KUP   = 3'd4,
		ACT_MDOWN = 3'd5,
		ACT_MUP   = 3'd6
	} action_t;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE_RELOAD = 1'b0,
		CFG_FRAME_DIVIDE    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic        keyboard_enabled;
		logic [10:0] frame_number;
		logic        button_pressed;
		logic        token_available;
		logic [15:0] token_word;
	} tick_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  key_code;
		logic [7:0]  modifier_mask;
		logic        token_taken;
		logic [7:0]  led_level;
		logic        led_update;
	} result_t;

endpackage

[hw/rtl/hks_in_reg.sv]
// input register stage holding one tick beat
module hks_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tick_valid,
	output logic          tick_stall,
	input  hks_pkg::tick_t tick,
	input  logic          advance,
	output logic          valid_s1,
	output hks_pkg::tick_t tick_s1
);

	logic load;

	assign tick_stall = valid_s1 && !advance;
	assign load       = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tick_s1 <= tick;
		end
	end

endmodule

[hw/rtl/hks_core.sv]
// playback state, configuration registers and per-tick result logic
module hks_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [0:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	input  logic            advance,
	input  hks_pkg::tick_t  tick_s1,
	output hks_pkg::result_t res
);

	logic [15:0]     debounce_reload_q;
	logic [7:0]      frame_divide_q;
	hks_pkg::phase_t phase_q, phase_d;
	logic [7:0]      prescale_q, prescale_d;
	logic [7:0]      pause_q, pause_d;
	logic [15:0]     debounce_q, debounce_d;
	logic [15:0]     held_q, held_d;

	logic [7:0]  pre_inc;
	logic [7:0]  pause_dec;
	logic [15:0] deb_dec;
	logic        active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_reload_q <= hks_pkg::DEBOUNCE_RELOAD_RST;
			frame_divide_q    <= hks_pkg::FRAME_DIVIDE_RST;
		end else if (cfg_we) begin
			unique case (hks_pkg::cfg_index_t'(cfg_index))
				hks_pkg::CFG_DEBOUNCE_RELOAD: debounce_reload_q <= cfg_data;
				hks_pkg::CFG_FRAME_DIVIDE:    frame_divide_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign pre_inc   = prescale_q + 8'd1;
	assign pause_dec = pause_q - 8'd1;
	assign deb_dec   = (debounce_q != 16'd0) ? debounce_q - 16'd1 : debounce_q;
	// compare is greater-or-equal so a divide below the count fires at once
	assign active    = tick_s1.keyboard_enabled && (pre_inc >= frame_divide_q);

	always_comb begin
		phase_d    = phase_q;
		prescale_d = prescale_q;
		pause_d    = pause_q;
		debounce_d = debounce_q;
		held_d     = held_q;
		res        = '0;
		res.action = hks_pkg::ACT_NONE;
		if (tick_s1.keyboard_enabled) begin
			if (active) begin
				prescale_d     = 8'd0;
				res.led_update = 1'b1;
				res.led_level  = tick_s1.frame_number[8:1];
				debounce_d     = deb_dec;
				unique case (phase_q)
					hks_pkg::PH_IDLE: begin
						if (tick_s1.button_pressed && deb_dec == 16'd0) begin
							phase_d    = hks_pkg::PH_START;
							debounce_d = debounce_reload_q;
						end
					end
					hks_pkg::PH_START: begin
						res.action = hks_pkg::ACT_OPEN;
						phase_d    = hks_pkg::PH_FETCH;
					end
					hks_pkg::PH_FETCH: begin
						if (!tick_s1.token_available) begin
							res.action = hks_pkg::ACT_CLOSE;
							phase_d    = hks_pkg::PH_IDLE;
						end else begin
							res.token_taken = 1'b1;
							held_d          = tick_s1.token_word;
							if (tick_s1.token_word[7:0] == 8'd0) begin
								// pause token, zero length wraps to 256
								pause_d = tick_s1.token_word[15:8];
								phase_d = hks_pkg::PH_PAUSE;
							end else if (tick_s1.token_word[15:8] == 8'd0) begin
								phase_d = hks_pkg::PH_KDOWN;
							end else begin
								phase_d = hks_pkg::PH_MDOWN;
							end
						end
					end
					hks_pkg::PH_KDOWN: begin
						res.action   = hks_pkg::ACT_KDOWN;
						res.key_code = held_q[7:0];
						phase_d      = hks_pkg::PH_KUP;
					end
					hks_pkg::PH_KUP: begin
						res.action   = hks_pkg::ACT_KUP;
						res.key_code = held_q[7:0];
						phase_d      = hks_pkg::PH_FETCH;
					end
					hks_pkg::PH_MDOWN: begin
						res.action        = hks_pkg::ACT_MDOWN;
						res.modifier_mask = held_q[15:8];
						phase_d           = hks_pkg::PH_MKDOWN;
					end
					hks_pkg::PH_MKDOWN: begin
						res.action   = hks_pkg::ACT_KDOWN;
						res.key_code = held_q[7:0];
						phase_d      = hks_pkg::PH_MKUP;
					end
					hks_pkg::PH_MKUP: begin
						res.action   = hks_pkg::ACT_KUP;
						res.key_code = held_q[7:0];
						phase_d      = hks_pkg::PH_MUP;
					end
					hks_pkg::PH_MUP: begin
						res.action        = hks_pkg::ACT_MUP;
						res.modifier_mask = held_q[15:8];
						phase_d           = hks_pkg::PH_FETCH;
					end
					hks_pkg::PH_PAUSE: begin
						pause_d = pause_dec;
						if (pause_dec == 8'd0) begin
							phase_d = hks_pkg::PH_FETCH;
						end
					end
					default: begin
						phase_d = hks_pkg::PH_IDLE;
					end
				endcase
			end else begin
				prescale_d = pre_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= hks_pkg::PH_START;
			prescale_q <= 8'd0;
			pause_q    <= 8'd0;
			debounce_q <= 16'd0;
			held_q     <= 16'd0;
		end else if (advance) begin
			phase_q    <= phase_d;
			prescale_q <= prescale_d;
			pause_q    <= pause_d;
			debounce_q <= debounce_d;
			held_q     <= held_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_taken_only_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.token_taken |-> phase_q == hks_pkg::PH_FETCH)
		else $error("token taken outside fetch phase");

	a_action_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.action != hks_pkg::ACT_NONE |-> res.led_update)
		else $error("action on an inactive tick");

	a_restart_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && active && phase_q == hks_pkg::PH_IDLE && tick_s1.button_pressed
		&& debounce_q <= 16'd1
		|=> phase_q == hks_pkg::PH_START && debounce_q == $past(debounce_reload_q))
		else $error("button restart did not reload debounce");
`endif

endmodule

[hw/rtl/hks_out_reg.sv]
// result register holding one result beat until taken
module hks_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  hks_pkg::result_t res,
	output logic             result_valid,
	input  logic             result_stall,
	output hks_pkg::result_t result
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= res;
		end
	end

endmodule

[hw/rtl/hid_keystroke_token_sequencer.sv]
// top level of the hid keystroke token sequencer
//
//  channel   direction  handshake                      payload
//  tick      in         tick_valid / tick_stall        hks_pkg::tick_t
//  result    out        result_valid / result_stall    hks_pkg::result_t
//  cfg       in         cfg_we                         cfg_index, cfg_data
//
// one tick beat in per cycle while tick_stall is low; its result beat leaves from the result register
// the tick passes an input register, then the playback logic writes the result register
// state and result register update together, so results leave in tick order
// reset puts playback in the start phase with all counts zero
// a stalled result holds the pipeline; one tick still fits in the input register
module hid_keystroke_token_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  hks_pkg::tick_t   tick,
	output logic             result_valid,
	input  logic             result_stall,
	output hks_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	logic             valid_s1;
	logic             advance;
	hks_pkg::tick_t   tick_s1;
	hks_pkg::result_t res;

	assign advance = valid_s1 && (!result_valid || !result_stall);

	hks_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.tick_s1    (tick_s1)
	);

	hks_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.tick_s1   (tick_s1),
		.res       (res)
	);

	hks_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.res          (res),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef NO_ASSERTIONS
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> valid_s1 && result_valid && result_stall)
		else $error("tick stalled with room in the pipeline");

	a_advance_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced beat did not reach result register");
`endif

endmodule

[tb/tb_top.sv]
// testbench for the hid keystroke token sequencer: directed tick table, then random ticks
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hks_pkg::*;

	typedef struct {
		tick_t   stim;
		bit      typed;
		result_t want;
	} script_row_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        tick_valid;
	logic        tick_stall;
	tick_t       tick;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	// predicted registers and playback state
	logic [15:0] play_reload;
	logic [7:0]  play_divide;
	phase_t      play_phase;
	logic [7:0]  play_prescale;
	logic [7:0]  play_pause;
	logic [15:0] play_debounce;
	logic [15:0] play_held;

	result_t     owed_results[$];
	script_row_t script[$];
	int          fault_count;
	int          burst_left;
	bit          long_pause_due;
	stall_mode_t stall_mode;
	int          stall_span;
	int          stall_run;
	bit          stall_level;

	hid_keystroke_token_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	// one frame tick through the playback machine
	function automatic result_t play_tick(tick_t t);
		result_t    r;
		logic [7:0] lo;
		logic [7:0] hi;
		r = '0;
		lo = play_held[7:0];
		hi = play_held[15:8];
		if (t.keyboard_enabled) begin
			play_prescale = play_prescale + 8'd1;
			if (play_prescale >= play_divide) begin
				play_prescale = 8'd0;
				r.led_update = 1'b1;
				r.led_level = t.frame_number[8:1];
				if (play_debounce != 16'd0)
					play_debounce = play_debounce - 16'd1;
				case (play_phase)
				PH_IDLE: begin
					if (t.button_pressed && play_debounce == 16'd0) begin
						play_phase = PH_START;
						play_debounce = play_reload;
					end
				end
				PH_START: begin
					r.action = ACT_OPEN;
					play_phase = PH_FETCH;
				end
				PH_FETCH: begin
					if (!t.token_available) begin
						r.action = ACT_CLOSE;
						play_phase = PH_IDLE;
					end else begin
						r.token_taken = 1'b1;
						play_held = t.token_word;
						if (play_held[7:0] == 8'd0) begin
							play_pause = play_held[15:8];
							play_phase = PH_PAUSE;
						end else if (play_held[15:8] == 8'd0) begin
							play_phase = PH_KDOWN;
						end else begin
							play_phase = PH_MDOWN;
						end
					end
				end
				PH_KDOWN: begin
					r.action = ACT_KDOWN;
					r.key_code = lo;
					play_phase = PH_KUP;
				end
				PH_KUP: begin
					r.action = ACT_KUP;
					r.key_code = lo;
					play_phase = PH_FETCH;
				end
				PH_MDOWN: begin
					r.action = ACT_MDOWN;
					r.modifier_mask = hi;
					play_phase = PH_MKDOWN;
				end
				PH_MKDOWN: begin
					r.action = ACT_KDOWN;
					r.key_code = lo;
					play_phase = PH_MKUP;
				end
				PH_MKUP: begin
					r.action = ACT_KUP;
					r.key_code = lo;
					play_phase = PH_MUP;
				end
				PH_MUP: begin
					r.action = ACT_MUP;
					r.modifier_mask = hi;
					play_phase = PH_FETCH;
				end
				PH_PAUSE: begin
					play_pause = play_pause - 8'd1;
					if (play_pause == 8'd0)
						play_phase = PH_FETCH;
				end
				default: begin
					play_phase = PH_IDLE;
				end
				endcase
			end
		end
		return r;
	endfunction

	function automatic void add_row(bit en, logic [10:0] frame, bit btn, bit avail,
			logic [15:0] word, bit typed = 1'b0, action_t act = ACT_NONE,
			logic [7:0] key = 8'd0, logic [7:0] mods = 8'd0, bit taken = 1'b0,
			logic [7:0] led = 8'd0, bit ledup = 1'b0);
		script_row_t row;
		row.stim.keyboard_enabled = en;
		row.stim.frame_number = frame;
		row.stim.button_pressed = btn;
		row.stim.token_available = avail;
		row.stim.token_word = word;
		row.typed = typed;
		row.want.action = act;
		row.want.key_code = key;
		row.want.modifier_mask = mods;
		row.want.token_taken = taken;
		row.want.led_level = led;
		row.want.led_update = ledup;
		script.push_back(row);
	endfunction

	// mostly well-formed token words, with some raw noise
	function automatic tick_t random_tick();
		tick_t      t;
		logic [7:0] lo;
		logic [7:0] hi;
		int         kind;
		t.keyboard_enabled = ($urandom_range(0, 9) != 0);
		t.frame_number = 11'($urandom_range(0, 2047));
		t.button_pressed = ($urandom_range(0, 3) == 0);
		t.token_available = ($urandom_range(0, 15) != 0);
		kind = $urandom_range(0, 19);
		if (kind < 8) begin
			lo = 8'($urandom_range(1, 255));
			hi = 8'd0;
		end else if (kind < 14) begin
			lo = 8'($urandom_range(1, 255));
			hi = 8'($urandom_range(1, 255));
		end else if (kind < 18) begin
			lo = 8'd0;
			hi = 8'($urandom_range(1, 4));
		end else begin
			{hi, lo} = 16'($urandom);
		end
		// a pause word of length zero runs for 256 active ticks
		if (long_pause_due && play_phase == PH_FETCH) begin
			t.keyboard_enabled = 1'b1;
			t.token_available = 1'b1;
			lo = 8'd0;
			hi = 8'd0;
		end
		t.token_word = {hi, lo};
		return t;
	endfunction

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_tick(tick_t t, bit typed, result_t want);
		result_t got;
		tick_valid <= 1'b1;
		tick <= t;
		do @(posedge clk); while (tick_stall);
		got = play_tick(t);
		owed_results.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic drain();
		tick_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_DEBOUNCE_RELOAD)
			play_reload = value;
		else
			play_divide = value[7:0];
		@(negedge clk);
	endtask

	task automatic run_phase(logic [15:0] reload, logic [7:0] divide, int count,
			bit want_long_pause);
		drain();
		write_reg(CFG_DEBOUNCE_RELOAD, reload);
		write_reg(CFG_FRAME_DIVIDE, {8'd0, divide});
		cfg_we <= 1'b0;
		long_pause_due = want_long_pause;
		repeat (count) begin
			pace();
			send_tick(random_tick(), 1'b0, '0);
			if (long_pause_due && play_phase == PH_PAUSE && play_pause == 8'd0)
				long_pause_due = 1'b0;
		end
	endtask

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fault_count++;
		end
	endfunction

	always @(posedge clk) begin : check_beat
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (owed_results.size() == 0) begin
				$display("%0t: result beat expected none got %h", $time, result);
				fault_count++;
			end else begin
				want = owed_results.pop_front();
				compare_field("action", want.action, result.action);
				compare_field("key_code", want.key_code, result.key_code);
				compare_field("modifier_mask", want.modifier_mask, result.modifier_mask);
				compare_field("token_taken", want.token_taken, result.token_taken);
				compare_field("led_level", want.led_level, result.led_level);
				compare_field("led_update", want.led_update, result.led_update);
			end
		end
	end

	// receiver stall: quiet stretches, random stalls, and long stall runs
	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 2));
			stall_span = $urandom_range(20, 150);
		end
		stall_span--;
		case (stall_mode)
		STALL_NONE: result_stall <= 1'b0;
		STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
		default: begin
			if (stall_run == 0) begin
				stall_level = !stall_level;
				stall_run = $urandom_range(1, 12);
			end
			stall_run--;
			result_stall <= stall_level;
		end
		endcase
	end

	initial begin
		arst_n = 1'b0;
		tick_valid = 1'b0;
		tick = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEBOUNCE_RELOAD;
		cfg_data = 16'd0;
		result_stall = 1'b0;
		fault_count = 0;
		burst_left = 0;
		long_pause_due = 1'b0;
		stall_mode = STALL_NONE;
		stall_span = 0;
		stall_run = 0;
		stall_level = 1'b0;
		play_reload = DEBOUNCE_RELOAD_RST;
		play_divide = FRAME_DIVIDE_RST;
		play_phase = PH_START;
		play_prescale = 8'd0;
		play_pause = 8'd0;
		play_debounce = 16'd0;
		play_held = 16'd0;

		// reset values: divide of two, so every second enabled tick is active
		add_row(1, 11'h000, 0, 0, 16'h0000, 1);
		add_row(1, 11'h7ff, 1, 1, 16'hffff, 1, ACT_OPEN, 8'h00, 8'h00, 0, 8'hff, 1);
		add_row(0, 11'h7ff, 1, 1, 16'hffff, 1);
		add_row(1, 11'h7ff, 1, 1, 16'hffff, 1);
		add_row(1, 11'h000, 0, 1, 16'hffff, 1, ACT_NONE, 8'h00, 8'h00, 1, 8'h00, 1);
		add_row(1, 11'h123, 0, 0, 16'h0000, 1);
		add_row(1, 11'h001, 0, 0, 16'h0000, 1, ACT_MDOWN, 8'h00, 8'hff, 0, 8'h00, 1);
		// rest of the modified key, then a plain key
		add_row(1, 11'h555, 1, 1, 16'h0004);
		add_row(1, 11'h2aa, 0, 1, 16'h0004);
		add_row(1, 11'h0f0, 1, 1, 16'h0004);
		add_row(1, 11'h70f, 0, 1, 16'h0004);
		add_row(1, 11'h3c3, 0, 1, 16'h0004);
		add_row(1, 11'h43c, 1, 1, 16'h0004);
		add_row(1, 11'h111, 0, 1, 16'h0004);
		add_row(1, 11'h6ee, 0, 1, 16'h0004);
		add_row(1, 11'h020, 1, 1, 16'h0004);
		add_row(1, 11'h7df, 0, 1, 16'h0004);
		add_row(1, 11'h246, 0, 1, 16'h0004);
		add_row(1, 11'h5b9, 0, 1, 16'h0004);
		// pause of one active tick
		add_row(1, 11'h00f, 0, 1, 16'h0100);
		add_row(1, 11'h0f0, 0, 1, 16'h0100);
		add_row(1, 11'h30c, 1, 1, 16'h0100);
		add_row(1, 11'h4f3, 0, 1, 16'h0100);
		// end of source, then the button restarts from idle
		add_row(1, 11'h7ff, 0, 0, 16'hffff);
		add_row(1, 11'h0fe, 0, 0, 16'hffff, 1, ACT_CLOSE, 8'h00, 8'h00, 0, 8'h7f, 1);
		add_row(1, 11'h3a5, 1, 0, 16'h0000);
		add_row(1, 11'h45a, 1, 0, 16'h0000);
		add_row(1, 11'h000, 0, 1, 16'h0000);
		add_row(1, 11'h1fe, 0, 1, 16'h0000, 1, ACT_OPEN, 8'h00, 8'h00, 0, 8'hff, 1);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		foreach (script[i]) begin
			pace();
			send_tick(script[i].stim, script[i].typed, script[i].want);
		end

		run_phase(16'd0, 8'd1, 350, 1'b1);
		run_phase(16'd3, 8'd0, 120, 1'b0);
		run_phase(16'hffff, 8'd3, 120, 1'b0);
		run_phase(16'd20, 8'd255, 250, 1'b0);
		drain();
		repeat (10) @(negedge clk);

		if (fault_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
